@@ rtl/min_image_pair_distance_defines.svh @@
// assertion macros for the minimum-image pair distance block
// no dependencies; included by the top level only
`ifndef MIN_IMAGE_PAIR_DISTANCE_DEFINES_SVH
`define MIN_IMAGE_PAIR_DISTANCE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MIPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mipd assertion failed");
`define MIPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mipd assertion failed");
`else
`define MIPD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MIPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/mipd_pkg.sv @@
// shared types and constants for the minimum-image pair distance block
// no dependencies; used by the interfaces, lanes, merge stage and top level
package mipd_pkg;

   localparam int PIPE_STAGES = 8;
   localparam int LANE_STAGES = 7;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_LENGTH     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_BOX_LENGTH = 4'd1;

   localparam logic [30:0] BOX_LENGTH_RESET     = 31'd65536;
   localparam logic [31:0] INV_BOX_LENGTH_RESET = 32'hFFFF_FFFF;

   // one half in the q16 fraction below the truncation point
   localparam logic [15:0] ROUND_HALF  = 16'h8000;
   localparam logic [30:0] DELTA_LIMIT = 31'h4000_0000;
   localparam logic [61:0] DIST_MAX    = 62'h3000_0000_0000_0000;

   typedef struct packed {
      logic [PIPE_STAGES:1] load;
   } pipe_ctl_type;

endpackage

@@ rtl/mipd_if.sv @@
// channel interfaces: coordinate pair request, distance response, register write
// depends on mipd_pkg
interface mipd_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] first_z;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;
   logic signed [COORD_WIDTH-1:0] second_z;
   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 output ready);
endinterface

interface mipd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] delta_x;
   logic signed [31:0] delta_y;
   logic signed [31:0] delta_z;
   logic        [61:0] distance_squared;
   modport source (output valid, delta_x, delta_y, delta_z, distance_squared, input ready);
   modport sink (input valid, delta_x, delta_y, delta_z, distance_squared, output ready);
endinterface

interface mipd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mipd_pkg::CSR_INDEX_W-1:0]   index;
   logic [31:0]                        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/min_image_pair_distance.sv @@
// Minimum-image pair distance in a cubic periodic box.
// req_ch carries the two particle positions, rsp_ch the three wrapped
// differences and the sum of their squares, csr_ch writes box_length
// (index 0) and inv_box_length (index 1); other indexes are ignored.
// Three axis lanes run side by side, each a seven-stage pipeline
// (difference, reciprocal multiply, rounding, count times length,
// residual, saturation, square); a merge stage adds the squares and is
// the output register.
// Throughput: one item per cycle while responses are taken, set by the fully pipelined lanes.
// Stalls: a held response holds the output stage; bubbles behind it are
// squeezed out and req_ch.ready drops only once all 8 stages are full.
// Reset: synchronous, clears every stage valid and loads box_length = 1.0
// and inv_box_length = 0xFFFFFFFF; csr writes are always accepted and
// must only be issued while the pipeline is empty.
// Depends on mipd_pkg, the mipd channel interfaces, mipd_lane, mipd_merge.
`include "min_image_pair_distance_defines.svh"

module min_image_pair_distance #(
   parameter int COORD_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   mipd_req_if.sink   req_ch,
   mipd_rsp_if.source rsp_ch,
   mipd_csr_if.sink   csr_ch
);

   localparam int STAGES = mipd_pkg::PIPE_STAGES;
   localparam int FILL_W = $clog2(STAGES + 1);

   // configuration registers
   logic [30:0] box_length_ff;
   logic [31:0] inv_box_length_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_length_ff     <= mipd_pkg::BOX_LENGTH_RESET;
         inv_box_length_ff <= mipd_pkg::INV_BOX_LENGTH_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            mipd_pkg::CSR_BOX_LENGTH: begin
               box_length_ff <= csr_ch.data[30:0];
            end
            mipd_pkg::CSR_INV_BOX_LENGTH: begin
               inv_box_length_ff <= csr_ch.data;
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline valid bits and per-stage load enables
   logic [STAGES:1]        valid_ff, valid_in;
   mipd_pkg::pipe_ctl_type ctl;

   always_comb begin
      ctl.load[STAGES] = !valid_ff[STAGES] || rsp_ch.ready;
      for (int i = STAGES - 1; i >= 1; i--) begin
         ctl.load[i] = !valid_ff[i] || ctl.load[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.load[1]) begin
         valid_in[1] = req_ch.valid;
      end
      for (int i = 2; i <= STAGES; i++) begin
         if (ctl.load[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = ctl.load[1];
   assign rsp_ch.valid = valid_ff[STAGES];

   // axis lanes
   logic signed [31:0] delta_x, delta_y, delta_z;
   logic        [60:0] square_x, square_y, square_z;

   mipd_lane #(.COORD_WIDTH(COORD_WIDTH)) lane_x (
      .clock          (clock),
      .ctl            (ctl),
      .coord_a        (req_ch.first_x),
      .coord_b        (req_ch.second_x),
      .box_length     (box_length_ff),
      .inv_box_length (inv_box_length_ff),
      .delta          (delta_x),
      .square         (square_x)
   );

   mipd_lane #(.COORD_WIDTH(COORD_WIDTH)) lane_y (
      .clock          (clock),
      .ctl            (ctl),
      .coord_a        (req_ch.first_y),
      .coord_b        (req_ch.second_y),
      .box_length     (box_length_ff),
      .inv_box_length (inv_box_length_ff),
      .delta          (delta_y),
      .square         (square_y)
   );

   mipd_lane #(.COORD_WIDTH(COORD_WIDTH)) lane_z (
      .clock          (clock),
      .ctl            (ctl),
      .coord_a        (req_ch.first_z),
      .coord_b        (req_ch.second_z),
      .box_length     (box_length_ff),
      .inv_box_length (inv_box_length_ff),
      .delta          (delta_z),
      .square         (square_z)
   );

   mipd_merge merge (
      .clock        (clock),
      .ctl          (ctl),
      .delta_x      (delta_x),
      .delta_y      (delta_y),
      .delta_z      (delta_z),
      .square_x     (square_x),
      .square_y     (square_y),
      .square_z     (square_z),
      .out_delta_x  (rsp_ch.delta_x),
      .out_delta_y  (rsp_ch.delta_y),
      .out_delta_z  (rsp_ch.delta_z),
      .out_distance (rsp_ch.distance_squared)
   );

   // checks
   logic              deltas_bounded;
   logic              dist_bounded;
   logic              item_in_only;
   logic [FILL_W-1:0] fill;

   assign deltas_bounded = (rsp_ch.delta_x <= 32'sd1073741824)
                        && (rsp_ch.delta_x >= -32'sd1073741824)
                        && (rsp_ch.delta_y <= 32'sd1073741824)
                        && (rsp_ch.delta_y >= -32'sd1073741824)
                        && (rsp_ch.delta_z <= 32'sd1073741824)
                        && (rsp_ch.delta_z >= -32'sd1073741824);
   assign dist_bounded   = rsp_ch.distance_squared <= mipd_pkg::DIST_MAX;
   assign item_in_only   = req_ch.valid && req_ch.ready && !(rsp_ch.valid && rsp_ch.ready);
   assign fill           = FILL_W'($countones(valid_ff));

   `MIPD_ASSERT_IMPLY(a_delta_bounded, clock, reset, rsp_ch.valid, deltas_bounded)
   `MIPD_ASSERT_IMPLY(a_dist_bounded, clock, reset, rsp_ch.valid, dist_bounded)
   `MIPD_ASSERT_NEXT(a_item_tracked, clock, reset, item_in_only, fill == $past(fill) + 1'b1)

endmodule

@@ rtl/mipd_lane.sv @@
// one axis: difference, reciprocal multiply, rounding, count times length, residual, saturation, square
// depends on mipd_pkg
module mipd_lane #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  mipd_pkg::pipe_ctl_type        ctl,
   input  logic signed [COORD_WIDTH-1:0] coord_a,
   input  logic signed [COORD_WIDTH-1:0] coord_b,
   input  logic        [30:0]            box_length,
   input  logic        [31:0]            inv_box_length,
   output logic signed [31:0]            delta,
   output logic        [60:0]            square
);

   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int HI_W  = (MAG_W > 32) ? MAG_W - 32 : 1;
   localparam int EXT_W = 32 + HI_W;
   localparam int PH_W  = HI_W + 32;
   localparam int U_W   = HI_W + 33;
   localparam int K_W   = U_W - 16;
   localparam int KH_W  = (K_W > 32) ? K_W - 32 : 1;
   localparam int KE_W  = 32 + KH_W;
   localparam int QH_W  = KH_W + 31;

   // stage 1: signed difference as sign and magnitude
   logic [MAG_W-1:0] diff;
   logic [MAG_W-1:0] mag1_in, mag1_ff;
   logic             neg1_ff;

   assign diff    = {coord_a[COORD_WIDTH-1], coord_a} - {coord_b[COORD_WIDTH-1], coord_b};
   assign mag1_in = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         neg1_ff <= diff[MAG_W-1];
         mag1_ff <= mag1_in;
      end
   end

   // stage 2: magnitude times reciprocal as two partial products
   logic [EXT_W-1:0] mag_ext;
   logic [63:0]      plo2_in, plo2_ff;
   logic [PH_W-1:0]  phi2_in, phi2_ff;
   logic [MAG_W-1:0] mag2_ff;
   logic             neg2_ff;

   assign mag_ext = EXT_W'(mag1_ff);
   assign plo2_in = 64'(mag_ext[31:0]) * 64'(inv_box_length);
   assign phi2_in = PH_W'(mag_ext[EXT_W-1:32]) * PH_W'(inv_box_length);

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         plo2_ff <= plo2_in;
         phi2_ff <= phi2_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // stage 3: add the half and truncate to the image count
   logic [U_W-1:0]   quot;
   logic [K_W-1:0]   k3_ff;
   logic [MAG_W-1:0] mag3_ff;
   logic             neg3_ff;

   assign quot = U_W'(phi2_ff) + U_W'(plo2_ff[63:32]) + U_W'(mipd_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         k3_ff   <= quot[U_W-1:16];
         mag3_ff <= mag2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   // stage 4: image count times box length as two partial products
   logic [KE_W-1:0]  k_ext;
   logic [62:0]      pl4_in, pl4_ff;
   logic [QH_W-1:0]  ph4_in, ph4_ff;
   logic [MAG_W-1:0] mag4_ff;
   logic             neg4_ff;

   assign k_ext  = KE_W'(k3_ff);
   assign pl4_in = 63'(k_ext[31:0]) * 63'(box_length);
   assign ph4_in = QH_W'(k_ext[KE_W-1:32]) * QH_W'(box_length);

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         pl4_ff  <= pl4_in;
         ph4_ff  <= ph4_in;
         mag4_ff <= mag3_ff;
         neg4_ff <= neg3_ff;
      end
   end

   // stage 5: residual modulo 2^64
   logic [63:0] r5_in, r5_ff;
   logic        neg5_ff;

   assign r5_in = 64'(mag4_ff) - 64'(pl4_ff) - (64'(ph4_ff) << 32);

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         r5_ff   <= r5_in;
         neg5_ff <= neg4_ff;
      end
   end

   // stage 6: residual magnitude, saturated, with the combined sign
   logic [63:0] r_abs;
   logic [30:0] mag6_in, mag6_ff;
   logic        neg6_in, neg6_ff;

   assign r_abs   = r5_ff[63] ? (~r5_ff + 64'd1) : r5_ff;
   assign mag6_in = (r_abs > 64'(mipd_pkg::DELTA_LIMIT)) ? mipd_pkg::DELTA_LIMIT
                                                          : r_abs[30:0];
   assign neg6_in = (neg5_ff != r5_ff[63]) && (mag6_in != 31'd0);

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         mag6_ff <= mag6_in;
         neg6_ff <= neg6_in;
      end
   end

   // stage 7: signed delta and its square
   logic [31:0] delta7_in, delta7_ff;
   logic [60:0] square7_in, square7_ff;

   assign delta7_in  = neg6_ff ? (32'd0 - 32'(mag6_ff)) : 32'(mag6_ff);
   assign square7_in = 61'(mag6_ff) * 61'(mag6_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         delta7_ff  <= delta7_in;
         square7_ff <= square7_in;
      end
   end

   assign delta  = $signed(delta7_ff);
   assign square = square7_ff;

endmodule

@@ rtl/mipd_merge.sv @@
// merge stage: sums the three squared deltas and holds the response payload
// depends on mipd_pkg
module mipd_merge (
   input  logic                   clock,
   input  mipd_pkg::pipe_ctl_type ctl,
   input  logic signed [31:0]     delta_x,
   input  logic signed [31:0]     delta_y,
   input  logic signed [31:0]     delta_z,
   input  logic        [60:0]     square_x,
   input  logic        [60:0]     square_y,
   input  logic        [60:0]     square_z,
   output logic signed [31:0]     out_delta_x,
   output logic signed [31:0]     out_delta_y,
   output logic signed [31:0]     out_delta_z,
   output logic        [61:0]     out_distance
);

   logic [61:0]        dist_in, dist_ff;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;

   assign dist_in = 62'(square_x) + 62'(square_y) + 62'(square_z);

   always_ff @(posedge clock) begin
      if (ctl.load[mipd_pkg::PIPE_STAGES]) begin
         dist_ff <= dist_in;
         dx_ff   <= delta_x;
         dy_ff   <= delta_y;
         dz_ff   <= delta_z;
      end
   end

   assign out_delta_x  = dx_ff;
   assign out_delta_y  = dy_ff;
   assign out_delta_z  = dz_ff;
   assign out_distance = dist_ff;

endmodule

@@ dv/min_image_pair_distance_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for min_image_pair_distance: streams coordinate pairs under several
// box settings and flow patterns and checks every result against a local minimum-image predictor
// depends on mipd_pkg, the mipd channel interfaces and the min_image_pair_distance rtl
module min_image_pair_distance_tb;

   localparam int COORD_W     = 32;
   localparam int CSR_W       = mipd_pkg::CSR_INDEX_W;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_PAIRS = 160;
   localparam int MAX_REPORTS = 20;

   localparam logic [CSR_W-1:0] CSR_INDEX_LAST = '1;

   localparam logic signed [COORD_W-1:0] Q_ONE     = 32'sh0001_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic [31:0] BOX_EIGHT = 32'h0008_0000;
   localparam logic [31:0] INV_EIGHT = 32'h2000_0000;
   localparam logic [31:0] INV_ZERO  = 32'h0000_0000;

   typedef enum {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RSP_STALLS, FLOW_BOTH} flow_mode_type;
   typedef enum {PAIR_WIDE, PAIR_NEAR, PAIR_TIE} pair_kind_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
   } pair_coords_type;

   typedef struct packed {
      logic [31:0] delta_x;
      logic [31:0] delta_y;
      logic [31:0] delta_z;
      logic [61:0] distance_squared;
   } pair_image_type;

   logic clock = 1'b0;
   logic reset;

   mipd_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   mipd_rsp_if                          rsp_bus ();
   mipd_csr_if                          csr_bus ();

   min_image_pair_distance #(.COORD_WIDTH(COORD_W)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // mirrored box registers and expected wrapped differences
   logic [30:0]     box_len;
   logic [31:0]     inv_len;
   pair_image_type  pending_images[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatches;
   int pairs_accepted;
   int results_checked;
   int settings_applied;
   int quiet_cycles;

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s at result %0d: got %h, expected %h",
                  what, results_checked, got, want);
   endtask

   function automatic void wrap_axis(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                                     output logic [31:0] delta, output logic [63:0] square);
      logic [63:0]  diff;
      logic [63:0]  span;
      logic [63:0]  turns;
      logic [63:0]  rem;
      logic [63:0]  rem_mag;
      logic [127:0] scaled;
      logic         diff_neg;
      logic         rem_neg;
      diff = {{(64-COORD_W){a[COORD_W-1]}}, a} - {{(64-COORD_W){b[COORD_W-1]}}, b};
      diff_neg = diff[63];
      span = diff_neg ? 64'd0 - diff : diff;
      scaled = 128'(span) * 128'(inv_len);
      scaled = scaled + (128'd1 << 47);
      turns = scaled[111:48];
      rem = span - turns * 64'(box_len);
      rem_neg = rem[63];
      rem_mag = rem_neg ? 64'd0 - rem : rem;
      if (rem_mag > 64'(mipd_pkg::DELTA_LIMIT))
         rem_mag = 64'(mipd_pkg::DELTA_LIMIT);
      delta = (diff_neg != rem_neg && rem_mag != 64'd0) ? 32'd0 - rem_mag[31:0]
                                                         : rem_mag[31:0];
      square = rem_mag * rem_mag;
   endfunction

   function automatic pair_image_type min_image_of(input pair_coords_type p);
      pair_image_type img;
      logic [63:0] sq_x;
      logic [63:0] sq_y;
      logic [63:0] sq_z;
      wrap_axis(p.first_x, p.second_x, img.delta_x, sq_x);
      wrap_axis(p.first_y, p.second_y, img.delta_y, sq_y);
      wrap_axis(p.first_z, p.second_z, img.delta_z, sq_z);
      img.distance_squared = 62'(sq_x + sq_y + sq_z);
      return img;
   endfunction

   // acceptance of items on all three channels, prediction and comparison
   always @(posedge clock) begin : scoreboard
      pair_image_type want;
      pair_coords_type seen;
      if (reset) begin
         box_len = mipd_pkg::BOX_LENGTH_RESET;
         inv_len = mipd_pkg::INV_BOX_LENGTH_RESET;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               mipd_pkg::CSR_BOX_LENGTH:     box_len = csr_bus.data[30:0];
               mipd_pkg::CSR_INV_BOX_LENGTH: inv_len = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            seen = {req_bus.first_x, req_bus.first_y, req_bus.first_z,
                    req_bus.second_x, req_bus.second_y, req_bus.second_z};
            pending_images.push_back(min_image_of(seen));
            pairs_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_images.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_bus.distance_squared), 64'd0);
            end else begin
               want = pending_images.pop_front();
               if (rsp_bus.delta_x !== want.delta_x)
                  report_mismatch("delta_x", 64'(rsp_bus.delta_x), 64'(want.delta_x));
               if (rsp_bus.delta_y !== want.delta_y)
                  report_mismatch("delta_y", 64'(rsp_bus.delta_y), 64'(want.delta_y));
               if (rsp_bus.delta_z !== want.delta_z)
                  report_mismatch("delta_z", 64'(rsp_bus.delta_z), 64'(want.delta_z));
               if (rsp_bus.distance_squared !== want.distance_squared)
                  report_mismatch("distance_squared", 64'(rsp_bus.distance_squared),
                                  64'(want.distance_squared));
               results_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no item moved for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, pending_images.size());
         $display("** min_image_pair_distance: FAILED **");
         $finish;
      end
   end

   task automatic set_flow(input flow_mode_type mode);
      case (mode)
         FLOW_FREE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         FLOW_SEND_GAPS: begin
            send_idle_pct = 86;
            rsp_stall_pct = 0;
         end
         FLOW_RSP_STALLS: begin
            send_idle_pct = 0;
            rsp_stall_pct = 86;
         end
         default: begin
            send_idle_pct = 16;
            rsp_stall_pct = 16;
         end
      endcase
   endtask

   // called at a falling edge, returns at the falling edge after the handshake with valid held
   task automatic send_pair(input pair_coords_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.first_x  <= p.first_x;
      req_bus.first_y  <= p.first_y;
      req_bus.first_z  <= p.first_z;
      req_bus.second_x <= p.second_x;
      req_bus.second_y <= p.second_y;
      req_bus.second_z <= p.second_z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      while (pending_images.size() != 0) @(negedge clock);
   endtask

   task automatic end_burst();
      req_bus.valid <= 1'b0;
      wait_quiet();
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] index, input logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // a write to an unmapped index goes first and must leave both registers alone
   task automatic apply_settings(input logic [31:0] box_word, input logic [31:0] inv_word);
      wait_quiet();
      write_reg(CSR_W'($urandom_range(mipd_pkg::CSR_INV_BOX_LENGTH + 1, CSR_INDEX_LAST)),
                $urandom);
      write_reg(mipd_pkg::CSR_BOX_LENGTH, box_word);
      write_reg(mipd_pkg::CSR_INV_BOX_LENGTH, inv_word);
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   function automatic pair_coords_type make_pair(
      input logic signed [COORD_W-1:0] fx, input logic signed [COORD_W-1:0] fy,
      input logic signed [COORD_W-1:0] fz, input logic signed [COORD_W-1:0] sx,
      input logic signed [COORD_W-1:0] sy, input logic signed [COORD_W-1:0] sz);
      pair_coords_type p;
      p = {fx, fy, fz, sx, sy, sz};
      return p;
   endfunction

   function automatic logic [31:0] consistent_inv(input logic [30:0] box);
      logic [63:0] q;
      if (box == 0)
         return 32'hFFFF_FFFF;
      q = (64'd1 << 48) / 64'(box);
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic [30:0] moderate_box();
      logic [30:0] b;
      b = 31'(($urandom_range(1, 64) << 16) | $urandom_range(0, 65535));
      return b;
   endfunction

   // whole box turns plus either a random fraction or a near-tie half box, random sign
   function automatic logic [63:0] near_offset(input bit at_tie);
      logic [63:0] turns;
      logic [63:0] frac;
      logic [63:0] mag;
      turns = 64'($urandom_range(0, 3));
      if (at_tie)
         frac = 64'(box_len >> 1) + 64'($urandom_range(0, 4)) - 64'd2;
      else
         frac = 64'($urandom_range(0, box_len));
      mag = turns * 64'(box_len) + frac;
      return $urandom_range(0, 1) ? 64'd0 - mag : mag;
   endfunction

   function automatic pair_coords_type pick_pair(input pair_kind_type kind);
      pair_coords_type p;
      logic [63:0]     off;
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (kind != PAIR_WIDE) begin
         off = near_offset(kind == PAIR_TIE);
         p.second_x = p.first_x - off[31:0];
         off = near_offset(kind == PAIR_TIE);
         p.second_y = p.first_y - off[31:0];
         off = near_offset(kind == PAIR_TIE);
         p.second_z = p.first_z - off[31:0];
      end
      return p;
   endfunction

   function automatic pair_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return PAIR_NEAR;
      else if (r < 80)
         return PAIR_TIE;
      return PAIR_WIDE;
   endfunction

   task automatic test_reset_settings();
      send_pair(make_pair(0, 0, 0, 0, 0, 0));
      send_pair(make_pair(Q_ONE / 2, -(Q_ONE / 2), 3 * Q_ONE + 1, 0, 0, 0));
      send_pair(make_pair(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, -1));
      send_pair(pick_pair(PAIR_NEAR));
      end_burst();
   endtask

   // box of 8.0 with an exact reciprocal so half-box ties round away from zero
   task automatic test_box_edges();
      apply_settings(BOX_EIGHT, INV_EIGHT);
      send_pair(make_pair(0, 0, 0, 0, 0, 0));
      send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_pair(make_pair(4 * Q_ONE, 0, 4 * Q_ONE - 1, 0, 4 * Q_ONE, 0));
      send_pair(make_pair(8 * Q_ONE, 0, 12 * Q_ONE, 0, 8 * Q_ONE, 0));
      send_pair(make_pair(4 * Q_ONE + 1, 0, 0, 0, 4 * Q_ONE + 1, 12 * Q_ONE));
      send_pair(make_pair(Q_ONE + Q_ONE / 2, -2 * Q_ONE, COORD_MAX,
                          Q_ONE + Q_ONE / 2, -2 * Q_ONE, COORD_MAX));
      send_pair(make_pair(COORD_MIN, 0, COORD_MAX, 0, COORD_MIN, -1));
      send_pair(make_pair(-3 * Q_ONE, 20 * Q_ONE, -1, 5 * Q_ONE, -20 * Q_ONE, 1));
      end_burst();
   endtask

   // no reciprocal: the raw difference comes out, clipped at a quarter of the range
   task automatic test_zero_reciprocal();
      apply_settings(BOX_EIGHT, INV_ZERO);
      send_pair(make_pair(COORD_MAX, COORD_MIN, 3 * Q_ONE, COORD_MIN, COORD_MAX, 0));
      send_pair(make_pair(32'sh4000_0000, 0, 32'sh4000_0001, 0, 32'sh4000_0000, 0));
      send_pair(make_pair(-5 * Q_ONE, 0, 32'sh3FFF_FFFF, 0, 32'sh4000_0001, 0));
      send_pair(pick_pair(PAIR_WIDE));
      end_burst();
   endtask

   task automatic test_short_box();
      apply_settings(32'd1, 32'hFFFF_FFFF);
      send_pair(pick_pair(PAIR_NEAR));
      send_pair(pick_pair(PAIR_WIDE));
      end_burst();
      apply_settings(32'd0, $urandom);
      send_pair(pick_pair(PAIR_WIDE));
      end_burst();
   endtask

   task automatic test_random_settings();
      logic [30:0] box;
      logic [31:0] inv;
      logic        box_msb;
      for (int i = 0; i < 12; i++) begin
         box = moderate_box();
         inv = consistent_inv(box);
         box_msb = 1'b0;
         case (i)
            0: begin
               box = 31'd65536;
               inv = consistent_inv(box);
            end
            1: begin
               box = 31'h7FFF_FFFF;
               inv = consistent_inv(box);
            end
            2: begin
               box = 31'($urandom_range(65536, 32'h7FFF_FFFF));
               inv = consistent_inv(box);
            end
            4: begin
               box = 31'd1 << $urandom_range(16, 30);
               inv = consistent_inv(box);
            end
            5: inv = $urandom;
            6: inv = 32'hFFFF_FFFF;
            7: inv = 32'd1;
            8: begin
               box = 31'($urandom_range(0, 65535));
               inv = $urandom;
            end
            9: inv = inv + $urandom_range(0, 8) - 32'd4;
            10: box_msb = 1'b1;
            default: ;
         endcase
         apply_settings({box_msb, box}, inv);
         set_flow(flow_mode_type'(i % 4));
         for (int n = 0; n < PHASE_PAIRS; n++)
            send_pair(pick_pair(pick_kind()));
         end_burst();
      end
      set_flow(FLOW_FREE);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.first_x = '0;
      req_bus.first_y = '0;
      req_bus.first_z = '0;
      req_bus.second_x = '0;
      req_bus.second_y = '0;
      req_bus.second_z = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      mismatches = 0;
      pairs_accepted = 0;
      results_checked = 0;
      settings_applied = 0;
      quiet_cycles = 0;
      set_flow(FLOW_FREE);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_settings();
      test_box_edges();
      test_zero_reciprocal();
      test_short_box();
      test_random_settings();

      wait_quiet();
      repeat (2 * mipd_pkg::PIPE_STAGES) @(negedge clock);
      if (pending_images.size() != 0)
         report_mismatch("missing results", 64'(pending_images.size()), 64'd0);

      $display("%0d coordinate pairs sent over %0d box settings and four flow patterns",
               pairs_accepted, settings_applied);
      $display("%0d results checked, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("** min_image_pair_distance: PASSED **");
      end else begin
         $display("** min_image_pair_distance: FAILED **");
      end
      $finish;
   end

endmodule
